FILE: design/event_packet_delineator_defines.svh
// Assertion macros for the checker file of the packet delineator.
// Depends on nothing; include it by its bare file name.
`ifndef EVENT_PACKET_DELINEATOR_DEFINES_SVH
`define EVENT_PACKET_DELINEATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/epd_pkg.sv
// Shared types, constants and helpers of the packet delineator.
// Depends on nothing; every other file but the defines header imports it.
package epd_pkg;

  localparam int WordW      = 16;
  localparam int IndexW     = 16;
  localparam int IndexBits  = 16;
  localparam int HistLen    = 12;
  localparam int IdxWideW   = (IndexBits > IndexW) ? IndexBits : IndexW;

  localparam int AMinEnd     = 19;
  localparam int BMinEnd     = 8;
  localparam int HeaderIndex = 7;

  localparam logic [WordW-1:0] AMarker   = 16'h8000;
  localparam logic [WordW-1:0] AMiddle   = 16'h0001;
  localparam logic [WordW-1:0] AAllOnes  = 16'hFFFF;
  localparam logic [3:0]       BHeadLow  = 4'h9;
  localparam logic [3:0]       BHeadHigh = 4'hA;
  localparam logic [3:0]       BTrlLow   = 4'hF;
  localparam logic [3:0]       BTrlHigh  = 4'hE;

  typedef logic [WordW-1:0]     word_t;
  typedef logic [IndexBits-1:0] pos_t;
  typedef logic [IndexW-1:0]    index_t;
  typedef logic [HistLen-1:0][WordW-1:0] hist_t;

  typedef enum logic [2:0] {
    ST_OUTSIDE = 3'd0,
    ST_A_START = 3'd1,
    ST_B_START = 3'd2,
    ST_A_BODY  = 3'd3,
    ST_B_BODY  = 3'd4,
    ST_A_END   = 3'd5,
    ST_B_END   = 3'd6
  } word_status_e;

  typedef struct packed {
    logic a_header;
    logic b_header;
    logic a_trailer;
    logic b_trailer;
  } match_t;

  // Each range in the framing rules covers one whole top nibble.
  function automatic logic top_nibble_is(word_t w, logic [3:0] nib);
    return w[WordW-1 -: 4] == nib;
  endfunction

endpackage

FILE: design/epd_word_if.sv
// Input channel of the packet delineator: one raw stream word per transfer.
// Depends on epd_pkg.
interface epd_word_if
  import epd_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

FILE: design/epd_result_if.sv
// Output channel of the packet delineator: one tagged word per transfer.
// Depends on epd_pkg.
interface epd_result_if
  import epd_pkg::*;
();
  logic         valid;
  logic         ready;
  word_t        word_out;
  word_status_e word_status;
  index_t       packet_index;

  modport source (output valid, output word_out, output word_status,
                  output packet_index, input ready);
  modport sink   (input valid, input word_out, input word_status,
                  input packet_index, output ready);
endinterface

FILE: design/epd_match.sv
// Parallel header and trailer compares over the shifted word history.
// Depends on epd_pkg.
module epd_match
  import epd_pkg::*;
(
  input  hist_t  hist_i,
  output match_t match_o
);

  logic b_hdr_low, b_hdr_high, b_trl_low, b_trl_high;

  always_comb begin
    b_hdr_low  = 1'b1;
    b_hdr_high = 1'b1;
    b_trl_low  = 1'b1;
    b_trl_high = 1'b1;
    for (int i = 4; i < 8; i++) begin
      b_hdr_low = b_hdr_low & top_nibble_is(hist_i[i], BHeadLow);
      b_trl_low = b_trl_low & top_nibble_is(hist_i[i], BTrlLow);
    end
    for (int i = 8; i < 11; i++) begin
      b_hdr_high = b_hdr_high & top_nibble_is(hist_i[i], BHeadHigh);
      b_trl_high = b_trl_high & top_nibble_is(hist_i[i], BTrlHigh);
    end
  end

  assign match_o.a_header  = (hist_i[9] == AMarker) && (hist_i[10] == AMiddle) &&
                             (hist_i[11] == AMarker);
  assign match_o.b_header  = b_hdr_low & b_hdr_high;
  assign match_o.a_trailer = (hist_i[0] == AMarker) && (hist_i[1] == AMarker) &&
                             (hist_i[2] == AAllOnes) && (hist_i[3] == AMarker);
  assign match_o.b_trailer = b_trl_low & b_trl_high;

endmodule

FILE: design/epd_framer.sv
// Framing state machine: word history, packet mode and word position.
// Depends on epd_pkg and epd_match.
module epd_framer
  import epd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  word_t        word_i,
  output word_status_e status_o,
  output index_t       index_o
);

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_A    = 2'd1,
    MODE_B    = 2'd2
  } mode_e;

  localparam pos_t PosMax = '1;

  mode_e  mode_q, mode_d;
  hist_t  hist_q, hist_d, hist_new;
  pos_t   pos_q, pos_d, pos_inc, pos_out;
  match_t match;
  logic   clear;
  logic [IdxWideW-1:0] pos_wide;

  always_comb begin
    for (int i = 0; i < HistLen - 1; i++) begin
      hist_new[i] = hist_q[i+1];
    end
    hist_new[HistLen-1] = word_i;
  end

  epd_match u_match (
    .hist_i  (hist_new),
    .match_o (match)
  );

  assign pos_inc = (pos_q != PosMax) ? pos_t'(pos_q + 1'b1) : pos_q;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pos_out  = '0;
    status_o = ST_OUTSIDE;
    clear    = 1'b0;
    case (mode_q)
      MODE_A: begin
        pos_out = pos_inc;
        pos_d   = pos_inc;
        if ((pos_inc >= pos_t'(AMinEnd)) && match.a_trailer) begin
          status_o = ST_A_END;
          clear    = 1'b1;
        end else begin
          status_o = ST_A_BODY;
        end
      end
      MODE_B: begin
        pos_out = pos_inc;
        pos_d   = pos_inc;
        if ((pos_inc >= pos_t'(BMinEnd)) && match.b_trailer) begin
          status_o = ST_B_END;
          clear    = 1'b1;
        end else begin
          status_o = ST_B_BODY;
        end
      end
      default: begin
        mode_d = MODE_HUNT;
        if (match.a_header) begin
          mode_d   = MODE_A;
          pos_d    = pos_t'(HeaderIndex);
          pos_out  = pos_t'(HeaderIndex);
          status_o = ST_A_START;
        end else if (match.b_header) begin
          mode_d   = MODE_B;
          pos_d    = pos_t'(HeaderIndex);
          pos_out  = pos_t'(HeaderIndex);
          status_o = ST_B_START;
        end
      end
    endcase
    hist_d = hist_new;
    if (clear) begin
      mode_d = MODE_HUNT;
      pos_d  = '0;
      hist_d = '0;
    end
  end

  assign pos_wide = IdxWideW'(pos_out);
  assign index_o  = (pos_wide > IdxWideW'({IndexW{1'b1}})) ? {IndexW{1'b1}}
                                                           : pos_wide[IndexW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      hist_q <= '0;
      pos_q  <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      hist_q <= hist_d;
      pos_q  <= pos_d;
    end
  end

endmodule

FILE: design/event_packet_delineator.sv
// Top level of the packet delineator: input register, framer, result register.
// Depends on epd_pkg, epd_word_if, epd_result_if and epd_framer.
//
//   port    direction  payload                                   transfer
//   in_i    sink       stream_word                               valid & ready
//   out_o   source     word_out, word_status, packet_index       valid & ready
//
// One word per cycle sustained while out_o is ready; a result passes the input
// register and then the result register before it is valid at out_o.
// The header and trailer compares and the state update happen in the same cycle, after
// the input register, so history, mode and position advance once per word.
// Reset clears the history to zero, the position to zero and starts hunting.
// A stalled out_o holds its result; in_i keeps taking words until the input
// register is also full.
module event_packet_delineator
  import epd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  epd_word_if.sink      in_i,
  epd_result_if.source  out_o
);

  logic         in_valid_q, in_valid_d;
  word_t        in_word_q;
  logic         out_valid_q, out_valid_d;
  word_t        out_word_q;
  word_status_e out_status_q;
  index_t       out_index_q;
  logic         advance, fire, in_take;
  word_status_e status;
  index_t       index;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign in_valid_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  epd_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fire),
    .word_i   (in_word_q),
    .status_o (status),
    .index_o  (index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_i.stream_word;
    end
    if (fire) begin
      out_word_q   <= in_word_q;
      out_status_q <= status;
      out_index_q  <= index;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.word_out     = out_word_q;
  assign out_o.word_status  = out_status_q;
  assign out_o.packet_index = out_index_q;

endmodule

FILE: design/epd_checker.sv
// Port-level checks of the packet delineator, bound to its top level.
// Depends on epd_pkg and event_packet_delineator_defines.svh.
`include "event_packet_delineator_defines.svh"

module epd_checker
  import epd_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input word_t        word_out_i,
  input logic [2:0]   word_status_i,
  input index_t       packet_index_i
);

  `EPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(word_out_i) && $stable(word_status_i) && $stable(packet_index_i))
  `EPD_ASSERT_SAME(a_start_index, clk_i, rst_ni, out_valid_i && (word_status_i == ST_A_START || word_status_i == ST_B_START), packet_index_i == index_t'(HeaderIndex))
  `EPD_ASSERT_SAME(a_outside_index, clk_i, rst_ni, out_valid_i && (word_status_i == ST_OUTSIDE), packet_index_i == '0)
  `EPD_ASSERT_SAME(a_end_index, clk_i, rst_ni, out_valid_i && (word_status_i == ST_A_END), packet_index_i >= index_t'(AMinEnd))

endmodule

bind event_packet_delineator epd_checker u_epd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .word_out_i     (out_o.word_out),
  .word_status_i  (out_o.word_status),
  .packet_index_i (out_o.packet_index)
);
